@@ hw/rtl/rob_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rob_pkg;

   localparam int QueueDepth = 4;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_RASTER_MODE   = 3'd0,
      CSR_PATTERN_FILL  = 3'd1,
      CSR_ROW_COUNT     = 3'd2,
      CSR_ROW_LENGTH    = 3'd3,
      CSR_SOURCE_STRIDE = 3'd4,
      CSR_DEST_STRIDE   = 3'd5,
      CSR_PATTERN_START = 3'd6,
      CSR_FILL_PATTERN  = 3'd7
   } csr_index_type;

   // operation the back end applies to the destination byte
   typedef enum logic [2:0] {
      OP_COPY = 3'd0,
      OP_OR   = 3'd1,
      OP_XOR  = 3'd2,
      OP_BIC  = 3'd3,
      OP_KEEP = 3'd4
   } rop_op_type;

   typedef struct packed {
      logic [2:0]  raster_mode;
      logic        pattern_fill;
      logic [15:0] row_count;
      logic [15:0] row_length;
      logic [15:0] source_stride;
      logic [15:0] dest_stride;
      logic [2:0]  pattern_start_row;
      logic [63:0] fill_pattern;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic [31:0] dest_offset;
      logic [31:0] source_offset;
      rop_op_type  op;
      logic [7:0]  src;
      logic [7:0]  dst;
      logic        last;
   } entry_type;

   // a size of zero stands for 65536
   function automatic logic [16:0] eff_size(input logic [15:0] v);
      logic [16:0] r;
      if (v == 16'd0) begin
         r = 17'h10000;
      end else begin
         r = {1'b0, v};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rob_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rob_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rob_pkg::cfg_type cfg,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [7:0]       source_byte,
   input  wire logic [7:0]       dest_byte,
   output logic                  push,
   input  wire logic             push_ready,
   output rob_pkg::entry_type    push_entry
);

   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [31:0] sbase_ff, sbase_in;
   logic [31:0] dbase_ff, dbase_in;
   logic [2:0]  pat_row_ff, pat_row_in;

   logic        job_start;
   logic [2:0]  cur_pat;
   logic [7:0]  pat_byte;
   logic        row_end;
   logic        job_end;
   logic        accept;

   assign in_ready = push_ready;
   assign accept   = in_valid && push_ready;
   assign push     = accept;

   always_comb begin
      job_start = (row_ff == 16'd0) && (col_ff == 16'd0);
      cur_pat   = job_start ? cfg.pattern_start_row : pat_row_ff;
      pat_byte  = cfg.fill_pattern[{cur_pat, 3'b000} +: 8];
      row_end   = ({1'b0, col_ff} + 17'd1) >= rob_pkg::eff_size(cfg.row_length);
      job_end   = row_end && (({1'b0, row_ff} + 17'd1) >= rob_pkg::eff_size(cfg.row_count));

      push_entry.dest_offset = dbase_ff + {16'd0, col_ff};
      push_entry.dst         = dest_byte;
      push_entry.last        = job_end;
      if (cfg.pattern_fill) begin
         push_entry.source_offset = 32'd0;
         push_entry.src           = pat_byte;
      end else begin
         push_entry.source_offset = sbase_ff + {16'd0, col_ff};
         push_entry.src           = cfg.raster_mode[2] ? ~source_byte : source_byte;
      end
      if (cfg.pattern_fill && cfg.raster_mode[2]) begin
         push_entry.op = rob_pkg::OP_KEEP;
      end else begin
         case (cfg.raster_mode[1:0])
            2'd0:    push_entry.op = rob_pkg::OP_COPY;
            2'd1:    push_entry.op = rob_pkg::OP_OR;
            2'd2:    push_entry.op = rob_pkg::OP_XOR;
            default: push_entry.op = rob_pkg::OP_BIC;
         endcase
      end

      row_in     = row_ff;
      col_in     = col_ff;
      sbase_in   = sbase_ff;
      dbase_in   = dbase_ff;
      pat_row_in = pat_row_ff;
      if (accept) begin
         if (job_end) begin
            row_in     = 16'd0;
            col_in     = 16'd0;
            sbase_in   = 32'd0;
            dbase_in   = 32'd0;
            pat_row_in = 3'd0;
         end else if (row_end) begin
            row_in     = row_ff + 16'd1;
            col_in     = 16'd0;
            sbase_in   = sbase_ff + {16'd0, cfg.source_stride};
            dbase_in   = dbase_ff + {16'd0, cfg.dest_stride};
            pat_row_in = cur_pat + 3'd1;
         end else begin
            col_in     = col_ff + 16'd1;
            pat_row_in = cur_pat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= 16'd0;
         col_ff     <= 16'd0;
         sbase_ff   <= 32'd0;
         dbase_ff   <= 32'd0;
         pat_row_ff <= 3'd0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         sbase_ff   <= sbase_in;
         dbase_ff   <= dbase_in;
         pat_row_ff <= pat_row_in;
      end
   end

   // end of job returns the walk to the origin
   a_job_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && job_end |=> row_ff == 16'd0 && col_ff == 16'd0 && dbase_ff == 32'd0)
      else $error("position not cleared after last transfer of job");

   // a row change always restarts the column
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      accept && row_end && !job_end |=> col_ff == 16'd0 && row_ff == $past(row_ff) + 16'd1)
      else $error("row advance broken");

endmodule

`default_nettype wire

@@ hw/rtl/rob_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rob_queue #(
   parameter int DEPTH = rob_pkg::QueueDepth
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    push_ready,
   input  wire rob_pkg::entry_type push_entry,
   output logic                    pop_valid,
   input  wire logic               pop,
   output rob_pkg::entry_type      pop_entry
);

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   rob_pkg::entry_type mem [DEPTH];

   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CountW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + CountW'(1))
      else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ hw/rtl/rob_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rob_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop,
   input  wire rob_pkg::entry_type pop_entry,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [71:0]             rsp_tdata,
   output logic                    rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [71:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic [7:0]  new_byte;
   logic        slot_free;

   assign slot_free  = !valid_ff || rsp_tready;
   assign pop        = pop_valid && slot_free;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      case (pop_entry.op)
         rob_pkg::OP_COPY: new_byte = pop_entry.src;
         rob_pkg::OP_OR:   new_byte = pop_entry.dst | pop_entry.src;
         rob_pkg::OP_XOR:  new_byte = pop_entry.dst ^ pop_entry.src;
         rob_pkg::OP_BIC:  new_byte = pop_entry.dst & ~pop_entry.src;
         default:          new_byte = pop_entry.dst;
      endcase

      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (slot_free) begin
         valid_in = pop_valid;
         data_in  = {new_byte, pop_entry.source_offset, pop_entry.dest_offset};
         last_in  = pop_entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/raster_op_blit_engine.sv @@
// Raster-operation byte blitter.
// req channel: one transfer per destination byte of the job in raster order,
//   req_tdata = source_byte [7:0], dest_byte [15:8].
// rsp channel: one transfer per request, in order, req_tdata fields turned into
//   dest_offset [31:0], source_offset [63:32], new_byte [71:64]; rsp_tlast
//   marks the final byte of the final row.
// csr channel: csr_index selects the register, csr_data carries its value;
//   csr_ready is always high. Write only while no request is in flight.
// Throughput: one byte per cycle while rsp_tready is high. The front end walks
//   the row and column counters and base adders in the cycle of the transfer
//   and writes a small queue; the back end applies the operation into an
//   output register. Each result passes from the queue into that register,
//   which drives rsp.
// Stall: with rsp_tready low the output register holds, the queue fills
//   (QUEUE_DEPTH entries) and req_tready drops when it is full.
// Reset: synchronous; position state returns to the job origin, the queue
//   empties and the registers take their defaults (row count and length 1).
`timescale 1ns / 1ps
`default_nettype none

module raster_op_blit_engine #(
   parameter int QUEUE_DEPTH = rob_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // source_byte, dest_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // dest_offset, source_offset, new_byte
   output logic             rsp_tlast,   // last_of_job
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   rob_pkg::cfg_type   cfg_ff, cfg_in;
   rob_pkg::entry_type push_entry;
   rob_pkg::entry_type pop_entry;
   logic               push;
   logic               push_ready;
   logic               pop;
   logic               pop_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rob_pkg::CSR_RASTER_MODE:   cfg_in.raster_mode       = csr_data[2:0];
            rob_pkg::CSR_PATTERN_FILL:  cfg_in.pattern_fill      = csr_data[0];
            rob_pkg::CSR_ROW_COUNT:     cfg_in.row_count         = csr_data[15:0];
            rob_pkg::CSR_ROW_LENGTH:    cfg_in.row_length        = csr_data[15:0];
            rob_pkg::CSR_SOURCE_STRIDE: cfg_in.source_stride     = csr_data[15:0];
            rob_pkg::CSR_DEST_STRIDE:   cfg_in.dest_stride       = csr_data[15:0];
            rob_pkg::CSR_PATTERN_START: cfg_in.pattern_start_row = csr_data[2:0];
            rob_pkg::CSR_FILL_PATTERN:  cfg_in.fill_pattern      = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raster_mode       <= 3'd0;
         cfg_ff.pattern_fill      <= 1'b0;
         cfg_ff.row_count         <= 16'd1;
         cfg_ff.row_length        <= 16'd1;
         cfg_ff.source_stride     <= 16'd0;
         cfg_ff.dest_stride       <= 16'd0;
         cfg_ff.pattern_start_row <= 3'd0;
         cfg_ff.fill_pattern      <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rob_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .source_byte (req_tdata[7:0]),
      .dest_byte   (req_tdata[15:8]),
      .push        (push),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   rob_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   rob_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
